// File: design/geo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geo_pkg: shared constants and types for the odometry unit
// Widths, CORDIC table, register indexes and the serial-multiplier control.
// ----------------------------------------------------------------------------
package geo_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ANG_LEN      = 30;
    localparam int STEPS_EFF    = (CORDIC_STEPS < ANG_LEN) ? CORDIC_STEPS : ANG_LEN;
    localparam int STEP_W       = 5;

    localparam logic [0:0] REG_MM_PER_STEP   = 1'b0;
    localparam logic [0:0] REG_HEADING_SCALE = 1'b1;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

    function automatic logic [31:0] atan_bam(input logic [STEP_W-1:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                5'd24: r = 32'h00000029;
                5'd25: r = 32'h00000014;
                5'd26: r = 32'h0000000A;
                5'd27: r = 32'h00000005;
                5'd28: r = 32'h00000003;
                5'd29: r = 32'h00000001;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    // serial multiplier command / status
    typedef struct packed {
        logic              start;
        logic signed [49:0] a;   // multiplicand
        logic [33:0]       b;    // unsigned multiplier, one bit per cycle
    } mul_cmd_t;

    typedef struct packed {
        logic              done;
        logic signed [83:0] p;
    } mul_sts_t;

endpackage

// File: design/geo_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geo interfaces: valid/ready channels
// Input item, result item and register write channels.
// ----------------------------------------------------------------------------
interface geo_in_if;
    logic              valid;
    logic              ready;
    logic              start_req;
    logic signed [15:0] x_steps;
    logic signed [15:0] y_steps;
    logic signed [15:0] gyro_rate;
    logic [31:0]       timestamp_us;
    modport source (output valid, start_req, x_steps, y_steps, gyro_rate, timestamp_us,
                    input ready);
    modport sink (input valid, start_req, x_steps, y_steps, gyro_rate, timestamp_us,
                  output ready);
endinterface

interface geo_out_if;
    logic              valid;
    logic              ready;
    logic signed [47:0] world_x;
    logic signed [47:0] world_y;
    logic [31:0]       heading;
    logic [31:0]       cycle_time_us;
    modport source (output valid, world_x, world_y, heading, cycle_time_us, input ready);
    modport sink (input valid, world_x, world_y, heading, cycle_time_us, output ready);
endinterface

interface geo_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: design/gyro_encoder_odometry_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_encoder_odometry_unit: gyro-aided encoder dead reckoning
// Heading integration, CORDIC sin/cos, world-frame rotation, saturating
// Q32.16 position accumulators.
// ----------------------------------------------------------------------------
//  channel   dir  transaction carries
//  in_ch     in   start_req, x_steps, y_steps, gyro_rate, timestamp_us
//  out_ch    out  world_x, world_y, heading, cycle_time_us
//  cfg_ch    in   index (0 mm_per_step, 1 heading_scale), data
//
// One item at a time. A start item goes straight to the output register. An
// integrating item runs eight products through one bit-serial multiplier plus
// the CORDIC. Reset clears pose, timestamp and registers. The result sits in
// an output register; the next item is taken once it has been handed over.
// ----------------------------------------------------------------------------
module gyro_encoder_odometry_unit (
    input  logic       clk,
    input  logic       rst_n,
    geo_in_if.sink     in_ch,
    geo_out_if.source  out_ch,
    geo_cfg_if.sink    cfg_ch
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_H1   = 4'd1;  // rate*scale
    localparam logic [3:0] S_H2   = 4'd2;  // *elapsed
    localparam logic [3:0] S_COR  = 4'd3;
    localparam logic [3:0] S_RX   = 4'd4;
    localparam logic [3:0] S_RY   = 4'd5;
    localparam logic [3:0] S_P1   = 4'd6;  // rx*c
    localparam logic [3:0] S_P2   = 4'd7;  // ry*s
    localparam logic [3:0] S_P3   = 4'd8;  // rx*s
    localparam logic [3:0] S_P4   = 4'd9;  // ry*c
    localparam logic [3:0] S_SUM  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0]  state_reg;
    logic [31:0] mm_reg, scale_reg;
    logic signed [47:0] acc_x_reg, acc_y_reg;
    logic [31:0] head_reg, last_ts_reg, cyc_reg;
    logic signed [15:0] xs_reg, ys_reg;
    logic signed [49:0] tmp_reg;
    logic signed [33:0] c_reg, s_reg;
    logic signed [39:0] rx_reg, ry_reg;   // steps * Q8.24 -> Q.16, 40 bits
    logic signed [83:0] sum_x_reg, sum_y_reg;
    logic        pend_reg;   // multiplier or CORDIC launched for current state

    geo_pkg::mul_cmd_t mcmd;
    geo_pkg::mul_sts_t msts;
    logic        cor_start, cor_done;
    logic signed [33:0] cor_c, cor_s;

    geo_mul u_mul (.clk(clk), .rst_n(rst_n), .cmd(mcmd), .sts(msts));
    geo_cordic u_cordic (.clk(clk), .rst_n(rst_n), .start(cor_start), .angle(head_reg),
                         .done(cor_done), .cos_o(cor_c), .sin_o(cor_s));

    assign cfg_ch.ready = (state_reg == S_IDLE);
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.world_x = acc_x_reg;
    assign out_ch.world_y = acc_y_reg;
    assign out_ch.heading = head_reg;
    assign out_ch.cycle_time_us = cyc_reg;

    // saturating adds, taken at S_SUM
    logic signed [48:0] dxs, dys, nx, ny;
    logic signed [47:0] satx, saty;
    assign dxs = 49'(sum_x_reg >>> 16);
    assign dys = 49'(sum_y_reg >>> 16);
    assign nx = 49'(acc_x_reg) + dxs;
    assign ny = 49'(acc_y_reg) + dys;
    assign satx = (nx > 49'(geo_pkg::ACC_MAX)) ? geo_pkg::ACC_MAX :
                  (nx < 49'(geo_pkg::ACC_MIN)) ? geo_pkg::ACC_MIN : nx[47:0];
    assign saty = (ny > 49'(geo_pkg::ACC_MAX)) ? geo_pkg::ACC_MAX :
                  (ny < 49'(geo_pkg::ACC_MIN)) ? geo_pkg::ACC_MIN : ny[47:0];

    // multiplier operand selection
    always_comb
    begin
        mcmd.start = 1'b0;
        mcmd.a = '0;
        mcmd.b = '0;
        case (state_reg)
            S_H1: begin mcmd.a = 50'(tmp_reg); mcmd.b = {2'b00, scale_reg}; end
            S_H2: begin mcmd.a = tmp_reg; mcmd.b = {2'b00, cyc_reg}; end
            S_RX: begin mcmd.a = 50'(xs_reg); mcmd.b = {2'b00, mm_reg}; end
            S_RY: begin mcmd.a = 50'(ys_reg); mcmd.b = {2'b00, mm_reg}; end
            // signed by signed: negate both if the multiplier is negative
            S_P1: begin mcmd.a = c_reg[33] ? -50'(rx_reg) : 50'(rx_reg);
                        mcmd.b = c_reg[33] ? 34'(-c_reg) : 34'(c_reg); end
            S_P2: begin mcmd.a = s_reg[33] ? -50'(ry_reg) : 50'(ry_reg);
                        mcmd.b = s_reg[33] ? 34'(-s_reg) : 34'(s_reg); end
            S_P3: begin mcmd.a = s_reg[33] ? -50'(rx_reg) : 50'(rx_reg);
                        mcmd.b = s_reg[33] ? 34'(-s_reg) : 34'(s_reg); end
            S_P4: begin mcmd.a = c_reg[33] ? -50'(ry_reg) : 50'(ry_reg);
                        mcmd.b = c_reg[33] ? 34'(-c_reg) : 34'(c_reg); end
            default: ;
        endcase
        if (!pend_reg && (state_reg == S_H1 || state_reg == S_H2 || state_reg == S_RX ||
            state_reg == S_RY || state_reg == S_P1 || state_reg == S_P2 ||
            state_reg == S_P3 || state_reg == S_P4))
            mcmd.start = 1'b1;
    end

    assign cor_start = (state_reg == S_COR) && !pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pend_reg    <= 1'b0;
            mm_reg      <= '0;
            scale_reg   <= '0;
            acc_x_reg   <= '0;
            acc_y_reg   <= '0;
            head_reg    <= '0;
            last_ts_reg <= '0;
            cyc_reg     <= '0;
        end
        else
        begin
            if (mcmd.start || cor_start)
                pend_reg <= 1'b1;
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_ch.valid)
                    begin
                        if (cfg_ch.index == geo_pkg::REG_MM_PER_STEP)
                            mm_reg <= cfg_ch.data;
                        else if (cfg_ch.index == geo_pkg::REG_HEADING_SCALE)
                            scale_reg <= cfg_ch.data;
                    end
                    if (in_ch.valid)
                    begin
                        last_ts_reg <= in_ch.timestamp_us;
                        xs_reg  <= in_ch.x_steps;
                        ys_reg  <= in_ch.y_steps;
                        tmp_reg <= 50'(in_ch.gyro_rate);
                        if (in_ch.start_req)
                        begin
                            acc_x_reg <= '0;
                            acc_y_reg <= '0;
                            head_reg  <= '0;
                            cyc_reg   <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            cyc_reg   <= in_ch.timestamp_us - last_ts_reg;
                            state_reg <= S_H1;
                        end
                    end
                end
                S_H1:
                    if (msts.done)
                    begin
                        tmp_reg <= msts.p[49:0];
                        pend_reg <= 1'b0;
                        state_reg <= S_H2;
                    end
                S_H2:
                    if (msts.done)
                    begin
                        head_reg <= head_reg + msts.p[47:16];
                        pend_reg <= 1'b0;
                        state_reg <= S_COR;
                    end
                S_COR:
                    if (cor_done)
                    begin
                        c_reg <= cor_c >>> 14;
                        s_reg <= cor_s >>> 14;
                        pend_reg <= 1'b0;
                        state_reg <= S_RX;
                    end
                S_RX:
                    if (msts.done)
                    begin
                        rx_reg <= 40'(msts.p[49:0] >>> 8);
                        pend_reg <= 1'b0;
                        state_reg <= S_RY;
                    end
                S_RY:
                    if (msts.done)
                    begin
                        ry_reg <= 40'(msts.p[49:0] >>> 8);
                        pend_reg <= 1'b0;
                        state_reg <= S_P1;
                    end
                S_P1:
                    if (msts.done)
                    begin
                        sum_x_reg <= msts.p;
                        pend_reg <= 1'b0;
                        state_reg <= S_P2;
                    end
                S_P2:
                    if (msts.done)
                    begin
                        sum_x_reg <= sum_x_reg - msts.p;
                        pend_reg <= 1'b0;
                        state_reg <= S_P3;
                    end
                S_P3:
                    if (msts.done)
                    begin
                        sum_y_reg <= msts.p;
                        pend_reg <= 1'b0;
                        state_reg <= S_P4;
                    end
                S_P4:
                    if (msts.done)
                    begin
                        sum_y_reg <= sum_y_reg + msts.p;
                        pend_reg <= 1'b0;
                        state_reg <= S_SUM;
                    end
                S_SUM:
                begin
                    acc_x_reg <= satx;
                    acc_y_reg <= saty;
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (out_ch.ready)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: design/geo_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geo_mul: bit-serial signed x unsigned multiplier
// Shift-add, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module geo_mul (
    input  logic             clk,
    input  logic             rst_n,
    input  geo_pkg::mul_cmd_t cmd,
    output geo_pkg::mul_sts_t sts
);
    logic               busy_reg, busy_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic signed [83:0] a_reg, a_next;
    logic [33:0]        b_reg, b_next;
    logic signed [83:0] p_reg, p_next;
    logic               done_reg, done_next;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            a_next    = 84'(cmd.a);
            b_next    = cmd.b;
            p_next    = '0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                p_next = p_reg + a_reg;
            a_next = a_reg <<< 1;
            b_next = b_reg >> 1;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd33)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        p_reg <= p_next;
    end

    assign sts.done = done_reg;
    assign sts.p    = p_reg;
endmodule

// File: design/geo_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geo_cordic: iterative sine/cosine
// One rotation step per cycle with quadrant fold; outputs in Q2.30.
// ----------------------------------------------------------------------------
module geo_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               done,
    output logic signed [33:0] cos_o,
    output logic signed [33:0] sin_o
);
    logic               busy_reg;
    logic               done_reg;
    logic               flip_reg;
    logic [geo_pkg::STEP_W-1:0] i_reg;
    logic signed [33:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic signed [33:0] xs, ys, at;
    logic               fold;
    logic [31:0]        ang_f;

    assign fold  = angle[31] ^ angle[30];
    assign ang_f = fold ? (angle + 32'h8000_0000) : angle;
    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign at = $signed({2'b00, geo_pkg::atan_bam(i_reg)});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
            end
            else if (busy_reg)
            begin
                i_reg <= i_reg + 1'b1;
                if (i_reg == geo_pkg::STEP_W'(geo_pkg::STEPS_EFF - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            flip_reg <= fold;
            x_reg    <= geo_pkg::CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= 34'($signed(ang_f));
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign done  = done_reg;
    assign cos_o = flip_reg ? -x_reg : x_reg;
    assign sin_o = flip_reg ? -y_reg : y_reg;
endmodule

// File: bench/gyro_encoder_odometry_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_encoder_odometry_unit_tb: self-checking bench for the odometry unit
// Drives directed and random sensor items through the valid/ready channels,
// predicts pose, heading and cycle time per item, checks every result.
// ----------------------------------------------------------------------------

// Expected pose for one transaction
typedef struct {
    logic signed [47:0] wx;
    logic signed [47:0] wy;
    logic [31:0]        hdg;
    logic [31:0]        cyc;
} pose_t;

class pose_scoreboard;
    logic [31:0]        mm_step;
    logic [31:0]        hscale;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic [31:0]        hdg;
    logic [31:0]        last_ts;
    pose_t              pending[$];
    int                 errors;

    function new();
        mm_step = 0; hscale = 0; pos_x = 0; pos_y = 0; hdg = 0; last_ts = 0;
        errors = 0;
    endfunction

    // floor division by 2^sh; >>> on signed is already a floor shift
    function automatic longint fshift(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic logic signed [47:0] sat48(longint a, longint d);
        longint r;
        r = a + d;
        if (r > 64'sd140737488355327) return 48'sh7FFF_FFFF_FFFF;
        if (r < -64'sd140737488355328) return 48'sh8000_0000_0000;
        return r[47:0];
    endfunction

    // CORDIC rotation of the binary angle, result in Q2.30
    function automatic void sincos(logic [31:0] ang, output longint c, output longint s);
        logic   flip;
        longint x, y, z, xs, ys;
        logic [31:0] a;
        flip = (ang + 32'h4000_0000) >> 31;
        a = flip ? ang + 32'h8000_0000 : ang;
        z = longint'(signed'(a));
        x = longint'(geo_pkg::CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < geo_pkg::STEPS_EFF; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= longint'(geo_pkg::atan_bam(i[4:0]));
            end
            else
            begin
                x += ys; y -= xs; z += longint'(geo_pkg::atan_bam(i[4:0]));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function void note_item(logic st, logic signed [15:0] xs, logic signed [15:0] ys,
                            logic signed [15:0] g, logic [31:0] ts);
        pose_t  p;
        logic [31:0] cyc;
        logic [63:0] d;
        longint c, s, rx, ry;
        if (st)
        begin
            pos_x = 0; pos_y = 0; hdg = 0; last_ts = ts; cyc = 0;
        end
        else
        begin
            cyc = ts - last_ts;
            last_ts = ts;
            d = 64'(longint'(g)) * 64'(hscale) * 64'(cyc);
            hdg += d[47:16];
            sincos(hdg, c, s);
            c = c >>> 14;
            s = s >>> 14;
            rx = (longint'(xs) * longint'(mm_step)) >>> 8;
            ry = (longint'(ys) * longint'(mm_step)) >>> 8;
            pos_x = sat48(pos_x, (rx * c - ry * s) >>> 16);
            pos_y = sat48(pos_y, (rx * s + ry * c) >>> 16);
        end
        p.wx = pos_x; p.wy = pos_y; p.hdg = hdg; p.cyc = cyc;
        pending.push_back(p);
    endfunction

    function void check_result(logic signed [47:0] wx, logic signed [47:0] wy,
                               logic [31:0] h, logic [31:0] cyc);
        pose_t p;
        if (pending.size() == 0)
        begin
            $error("unexpected result transaction");
            errors++;
            return;
        end
        p = pending.pop_front();
        if (wx !== p.wx) begin $error("world_x exp %0d got %0d", p.wx, wx); errors++; end
        if (wy !== p.wy) begin $error("world_y exp %0d got %0d", p.wy, wy); errors++; end
        if (h !== p.hdg) begin $error("heading exp %h got %h", p.hdg, h); errors++; end
        if (cyc !== p.cyc)
        begin
            $error("cycle_time_us exp %0d got %0d", p.cyc, cyc);
            errors++;
        end
    endfunction
endclass

module gyro_encoder_odometry_unit_tb;

    logic clk;
    logic rst_n;
    geo_in_if  in_ch();
    geo_out_if out_ch();
    geo_cfg_if cfg_ch();

    gyro_encoder_odometry_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    pose_scoreboard sb = new();
    longint cycles;
    logic   stall_burst;   // asks the receiver for one long hold-off
    logic [31:0] ts_now;   // running timestamp for random items

    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    // random gap: mostly short, sometimes long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 0; in_ch.start_req = 0; in_ch.x_steps = 0; in_ch.y_steps = 0;
        in_ch.gyro_rate = 0; in_ch.timestamp_us = 0;
        cfg_ch.valid = 0; cfg_ch.index = geo_pkg::REG_MM_PER_STEP; cfg_ch.data = 0;
        out_ch.ready = 0;
        stall_burst = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // timeout watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 4000000)
            begin
                $display("gyro_encoder_odometry_unit_tb failed");
                $finish;
            end
        end
    end

    // receiver: random ready, one long hold-off when asked
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.world_x, out_ch.world_y, out_ch.heading,
                                out_ch.cycle_time_us);
            if (stall_burst)
            begin
                out_ch.ready <= 1'b0;
                stall_burst <= 1'b0;
                repeat (800) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else
            begin
                g = gap_len();
                if (g == 0 || $urandom_range(0, 3) == 0)
                    out_ch.ready <= 1'b1;
                else
                    out_ch.ready <= 1'b0;
            end
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == geo_pkg::REG_MM_PER_STEP) sb.mm_step = val;
        else sb.hscale = val;
    endtask

    // offer one item, hold until accepted, then drop valid for a random gap
    task automatic send_item(logic st, logic [15:0] xs, logic [15:0] ys,
                             logic [15:0] g, logic [31:0] ts);
        int n;
        in_ch.valid        <= 1'b1;
        in_ch.start_req    <= st;
        in_ch.x_steps      <= xs;
        in_ch.y_steps      <= ys;
        in_ch.gyro_rate    <= g;
        in_ch.timestamp_us <= ts;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_item(st, xs, ys, g, ts);
        n = gap_len();
        // the unit is busy after accepting a transaction
        in_ch.valid <= 1'b0;
        repeat (n + 1) @(posedge clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        in_ch.valid <= 1'b0;
        repeat (20) @(posedge clk);
    endtask

    task automatic random_item();
        logic [15:0] g;
        int k;
        k = $urandom_range(0, 99);
        ts_now += (k < 5) ? $urandom() : $urandom_range(0, 2000);
        g = (k < 10) ? 16'($urandom()) : 16'($urandom_range(0, 600) - 300);
        send_item(k < 3, 16'($urandom()), 16'($urandom()), g, ts_now);
    endtask

    initial
    begin
        logic [31:0] mms[4];
        logic [31:0] hss[4];
        @(posedge rst_n);
        @(posedge clk);
        ts_now = 0;

        // directed: first item measures from reset timestamp 0, registers at reset
        send_item(0, 16'h7FFF, 16'h8000, 16'h7FFF, 32'd1000);
        drain();
        write_reg(geo_pkg::REG_MM_PER_STEP, 32'h0100_0000);
        write_reg(geo_pkg::REG_HEADING_SCALE, 32'h0001_0000);
        drain();
        send_item(1, 0, 0, 0, 32'hFFFF_FFF0);            // start
        send_item(0, 16'd100, 16'd0, 16'd1000, 32'h0000_0010); // timestamp wrap
        send_item(0, 16'h8000, 16'h7FFF, 16'h8000, 32'h0000_1010);
        send_item(0, 16'hFFFF, 16'h0001, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(0, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
        drain();
        // largest scale: both registers at their maximum value
        write_reg(geo_pkg::REG_MM_PER_STEP, 32'hFFFF_FFFF);
        write_reg(geo_pkg::REG_HEADING_SCALE, 32'hFFFF_FFFF);
        for (int i = 0; i < 12; i++)
            send_item(0, 16'h7FFF, 16'h7FFF, 16'(i * 5000), 32'(i * 7));
        drain();
        write_reg(geo_pkg::REG_HEADING_SCALE, 32'h0);
        for (int i = 0; i < 6; i++)
            send_item(0, 16'h8000, 16'h8000, 16'h7FFF, 32'(i * 13));
        drain();

        // random phases through several register settings
        mms = '{32'h0000_0000, 32'h0080_0000, 32'h0400_0000, 32'hFFFF_FFFF};
        hss = '{32'h0000_0000, 32'h0000_4000, 32'h0010_0000, 32'hFFFF_FFFF};
        for (int p = 0; p < 6; p++)
        begin
            write_reg(geo_pkg::REG_MM_PER_STEP, (p < 4) ? mms[p] : $urandom());
            write_reg(geo_pkg::REG_HEADING_SCALE, (p < 4) ? hss[3 - p] : $urandom());
            send_item(1, 0, 0, 0, ts_now);
            for (int i = 0; i < 200; i++)
            begin
                if (p == 2 && i == 20) stall_burst <= 1'b1;
                random_item();
            end
            drain();
        end

        drain();
        repeat (400) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("gyro_encoder_odometry_unit_tb passed");
        else
            $display("gyro_encoder_odometry_unit_tb failed");
        $finish;
    end
endmodule
